// ===== design/grid_bilinear_interpolator_defines.svh =====
// assertion macros for the grid bilinear interpolator
`ifndef GRID_BILINEAR_INTERPOLATOR_DEFINES_SVH
`define GRID_BILINEAR_INTERPOLATOR_DEFINES_SVH

// same-cycle implication, checked on every rising edge out of reset
`define GBI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gbi assertion failed");

// next-cycle implication
`define GBI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gbi assertion failed");

`endif

// ===== design/gbi_pkg.sv =====
// shared types and constants of the grid bilinear interpolator
`timescale 1ns / 1ps

package gbi_pkg;

  localparam int DEF_MAX_X_NODES = 64;
  localparam int DEF_MAX_Y_NODES = 64;

  localparam int OP_W    = 2;
  localparam int IDX_W   = 6;
  localparam int VAL_W   = 32;
  localparam int COUNT_W = 7;
  localparam int TOL_W   = 16;
  localparam int CFG_W   = 16;
  localparam int CFGI_W  = 2;
  localparam int Q_W     = 16;
  localparam int RATIO_W = 17;
  localparam int DCW     = $clog2(Q_W + 1);
  localparam int BSW     = 4;

  localparam logic [COUNT_W-1:0] RST_NODE_COUNT = COUNT_W'(2);
  localparam logic [TOL_W-1:0]   RST_SNAP_TOL   = TOL_W'(7);
  localparam logic [RATIO_W-1:0] RATIO_ONE      = RATIO_W'(65536);
  localparam logic [BSW-1:0]     BLEND_LAST     = BSW'(8);

  typedef enum logic [OP_W-1:0] {
    OP_WRITE_X      = 2'd0,
    OP_WRITE_Y      = 2'd1,
    OP_WRITE_HEIGHT = 2'd2,
    OP_QUERY        = 2'd3
  } op_t;

  typedef enum logic [CFGI_W-1:0] {
    CFG_X_COUNT  = 2'd0,
    CFG_Y_COUNT  = 2'd1,
    CFG_SNAP_TOL = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic latch;
    logic write;
    logic scan_start;
    logic scan_run;
    logic resolve;
    logic div_run;
    logic blend_run;
    logic load_result;
    logic axis;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic scan_done;
    logic need_div;
    logic div_done;
    logic blend_done;
  } status_t;

endpackage

// ===== design/gbi_ctrl.sv =====
// sequencing state machine of the grid bilinear interpolator
`timescale 1ns / 1ps

module gbi_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output gbi_pkg::cmd_t   cmd,
  input  gbi_pkg::status_t st
);
  import gbi_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_WRITE, S_SCAN_START, S_SCAN, S_RESOLVE, S_DIVIDE, S_BLEND, S_EMIT
  } state_t;

  state_t state;
  logic   axis;
  logic   accept;
  logic   slot_free;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    cmd             = '0;
    cmd.axis        = axis;
    cmd.latch       = accept;
    cmd.write       = (state == S_WRITE);
    cmd.scan_start  = (state == S_SCAN_START);
    cmd.scan_run    = (state == S_SCAN);
    cmd.resolve     = (state == S_RESOLVE);
    cmd.div_run     = (state == S_DIVIDE);
    cmd.blend_run   = (state == S_BLEND);
    cmd.load_result = (state == S_EMIT) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      axis      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // a new result may replace one taken in the same cycle
      if (state == S_EMIT && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            axis  <= 1'b0;
            state <= (st.op == OP_QUERY) ? S_SCAN_START : S_WRITE;
          end
        end
        S_WRITE: state <= S_IDLE;
        S_SCAN_START: state <= S_SCAN;
        S_SCAN: begin
          if (st.scan_done) state <= S_RESOLVE;
        end
        S_RESOLVE: begin
          if (st.need_div) begin
            state <= S_DIVIDE;
          end else if (axis) begin
            state <= S_BLEND;
          end else begin
            axis  <= 1'b1;
            state <= S_SCAN_START;
          end
        end
        S_DIVIDE: begin
          if (st.div_done) begin
            if (axis) begin
              state <= S_BLEND;
            end else begin
              axis  <= 1'b1;
              state <= S_SCAN_START;
            end
          end
        end
        S_BLEND: begin
          if (st.blend_done) state <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/gbi_datapath.sv =====
// node memories, axis scan, ratio divider and blend of the interpolator
`timescale 1ns / 1ps

module gbi_datapath #(
  parameter int MAX_X_NODES = gbi_pkg::DEF_MAX_X_NODES,
  parameter int MAX_Y_NODES = gbi_pkg::DEF_MAX_Y_NODES
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [gbi_pkg::CFGI_W-1:0]          cfg_index,
  input  logic [gbi_pkg::CFG_W-1:0]           cfg_data,
  input  gbi_pkg::op_t                        operation,
  input  logic [gbi_pkg::IDX_W-1:0]           node_x_index,
  input  logic [gbi_pkg::IDX_W-1:0]           node_y_index,
  input  logic signed [gbi_pkg::VAL_W-1:0]    write_value,
  input  logic signed [gbi_pkg::VAL_W-1:0]    query_x,
  input  logic signed [gbi_pkg::VAL_W-1:0]    query_y,
  input  gbi_pkg::cmd_t                       cmd,
  output gbi_pkg::status_t                    st,
  output logic signed [gbi_pkg::VAL_W-1:0]    height,
  output logic [gbi_pkg::IDX_W-1:0]           cell_x,
  output logic [gbi_pkg::IDX_W-1:0]           cell_y,
  output logic [gbi_pkg::RATIO_W-1:0]         ratio_x,
  output logic [gbi_pkg::RATIO_W-1:0]         ratio_y
);
  import gbi_pkg::*;

  localparam int XAW  = $clog2(MAX_X_NODES);
  localparam int YAW  = $clog2(MAX_Y_NODES);
  localparam int MAXN = (MAX_X_NODES > MAX_Y_NODES) ? MAX_X_NODES : MAX_Y_NODES;
  localparam int NW   = $clog2(MAXN + 1);
  localparam int HD   = MAX_X_NODES * MAX_Y_NODES;
  localparam int HAW  = $clog2(HD);
  localparam int DW   = VAL_W + 1;
  localparam int PW   = VAL_W + RATIO_W + 1;
  localparam int TW   = PW + 1;
  localparam int AW   = TW + RATIO_W + 1;

  // configuration
  logic [COUNT_W-1:0] x_count, y_count;
  logic [TOL_W-1:0]   snap_tol;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_count  <= RST_NODE_COUNT;
      y_count  <= RST_NODE_COUNT;
      snap_tol <= RST_SNAP_TOL;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_X_COUNT:  x_count  <= cfg_data[COUNT_W-1:0];
        CFG_Y_COUNT:  y_count  <= cfg_data[COUNT_W-1:0];
        CFG_SNAP_TOL: snap_tol <= cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // latched request
  op_t                     op_r;
  logic [IDX_W-1:0]        xi_r, yi_r;
  logic signed [VAL_W-1:0] wv_r, qx_r, qy_r;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r <= operation;
      xi_r <= node_x_index;
      yi_r <= node_y_index;
      wv_r <= write_value;
      qx_r <= query_x;
      qy_r <= query_y;
    end
  end

  // node counts clamped to at least 2 and at most the storage size
  logic [NW-1:0] nx, ny, n_sel, n_last, n_pen;

  always_comb begin
    if (32'(x_count) < 2) nx = NW'(2);
    else if (32'(x_count) > MAX_X_NODES) nx = NW'(MAX_X_NODES);
    else nx = NW'(x_count);
    if (32'(y_count) < 2) ny = NW'(2);
    else if (32'(y_count) > MAX_Y_NODES) ny = NW'(MAX_Y_NODES);
    else ny = NW'(y_count);
    n_sel  = cmd.axis ? ny : nx;
    n_last = n_sel - NW'(1);
    n_pen  = n_sel - NW'(2);
  end

  // memories
  logic signed [VAL_W-1:0] xpos [MAX_X_NODES];
  logic signed [VAL_W-1:0] ypos [MAX_Y_NODES];
  logic signed [VAL_W-1:0] hmem [HD];
  logic signed [VAL_W-1:0] xrd, yrd, hrd;
  logic [NW-1:0]           rk;
  logic [HAW-1:0]          hwa, hra;
  logic                    x_ok, y_ok;
  logic [NW-1:0]           cx, cy;
  logic [BSW-1:0]          bstep;

  assign x_ok = 32'(xi_r) < MAX_X_NODES;
  assign y_ok = 32'(yi_r) < MAX_Y_NODES;
  assign hwa  = HAW'(XAW'(xi_r)) * HAW'(MAX_Y_NODES) + HAW'(YAW'(yi_r));
  assign hra  = (HAW'(cx) + HAW'(bstep[1])) * HAW'(MAX_Y_NODES)
              + HAW'(cy) + HAW'(bstep[0]);

  always_ff @(posedge clk) begin
    if (cmd.write && op_r == OP_WRITE_X && x_ok) xpos[XAW'(xi_r)] <= wv_r;
    xrd <= xpos[rk[XAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.write && op_r == OP_WRITE_Y && y_ok) ypos[YAW'(yi_r)] <= wv_r;
    yrd <= ypos[rk[YAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.write && op_r == OP_WRITE_HEIGHT && x_ok && y_ok) hmem[hwa] <= wv_r;
    hrd <= hmem[hra];
  end

  // node scan: one node per cycle; each position is read into a register and compared in the cycle after its address
  logic                    pv;
  logic [NW-1:0]           ek, snap_k, int_k;
  logic                    low_f, high_f, snap_f, int_f;
  logic signed [VAL_W-1:0] v_sel, cur, prev, lo, hi;
  logic signed [DW-1:0]    diff;
  logic [DW-1:0]           absd;
  logic                    snap_hit, int_hit;

  always_comb begin
    v_sel    = cmd.axis ? qy_r : qx_r;
    cur      = cmd.axis ? yrd : xrd;
    diff     = DW'(v_sel) - DW'(cur);
    absd     = diff[DW-1] ? DW'(-diff) : DW'(diff);
    snap_hit = (diff == '0) || (absd < DW'(snap_tol));
    int_hit  = (ek != '0) && (prev < v_sel) && (v_sel < cur);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rk     <= '0;
      pv     <= 1'b0;
      low_f  <= 1'b0;
      high_f <= 1'b0;
      snap_f <= 1'b0;
      int_f  <= 1'b0;
    end else if (cmd.scan_start) begin
      rk     <= '0;
      pv     <= 1'b0;
      low_f  <= 1'b0;
      high_f <= 1'b0;
      snap_f <= 1'b0;
      int_f  <= 1'b0;
    end else if (cmd.scan_run) begin
      pv <= (rk < n_sel);
      if (rk < n_sel) rk <= rk + NW'(1);
      if (pv) begin
        if (ek == '0 && v_sel < cur) low_f <= 1'b1;
        if (ek == n_last && v_sel > cur) high_f <= 1'b1;
        if (!snap_f && snap_hit) snap_f <= 1'b1;
        if (!int_f && int_hit) int_f <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_run) begin
      ek <= rk;
      if (pv) begin
        prev <= cur;
        if (!snap_f && snap_hit) snap_k <= ek;
        if (!int_f && int_hit) begin
          int_k <= ek - NW'(1);
          lo    <= prev;
          hi    <= cur;
        end
      end
    end
  end

  // per-axis outcome
  logic [NW-1:0]      res_cell;
  logic [RATIO_W-1:0] res_ratio;

  always_comb begin
    res_cell  = '0;
    res_ratio = '0;
    if (low_f) begin
      res_cell = '0;
    end else if (high_f) begin
      res_cell  = n_pen;
      res_ratio = RATIO_ONE;
    end else if (snap_f) begin
      if (snap_k == n_last) begin
        res_cell  = n_pen;
        res_ratio = RATIO_ONE;
      end else begin
        res_cell = snap_k;
      end
    end else if (int_f) begin
      res_cell = int_k;
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [DCW-1:0] dcnt;
  logic [DW-1:0]  rem, den;
  logic [DW:0]    rem2;
  logic [Q_W-1:0] quo;

  assign rem2 = {rem, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt <= '0;
    end else if (cmd.resolve) begin
      dcnt <= '0;
    end else if (cmd.div_run && !st.div_done) begin
      dcnt <= dcnt + DCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resolve) begin
      rem <= DW'(v_sel) - DW'(lo);
      den <= DW'(hi) - DW'(lo);
      quo <= '0;
    end else if (cmd.div_run && !st.div_done) begin
      if (rem2 >= {1'b0, den}) begin
        rem <= DW'(rem2 - {1'b0, den});
        quo <= {quo[Q_W-2:0], 1'b1};
      end else begin
        rem <= DW'(rem2);
        quo <= {quo[Q_W-2:0], 1'b0};
      end
    end
  end

  // cell and ratio of each axis
  logic [RATIO_W-1:0] rx, ry;

  always_ff @(posedge clk) begin
    if (cmd.resolve) begin
      if (cmd.axis) begin
        cy <= res_cell;
        ry <= res_ratio;
      end else begin
        cx <= res_cell;
        rx <= res_ratio;
      end
    end else if (cmd.div_run && st.div_done) begin
      if (cmd.axis) ry <= RATIO_W'(quo);
      else rx <= RATIO_W'(quo);
    end
  end

  // blend: y weights per corner, then x weights per row
  logic signed [RATIO_W:0] wy_m, wx_m;
  logic signed [PW-1:0]    p;
  logic signed [TW-1:0]    t;
  logic signed [AW-1:0]    q, acc, rnd;

  assign wy_m = bstep[0] ? $signed({1'b0, RATIO_ONE - ry}) : $signed({1'b0, ry});
  assign wx_m = (bstep == BSW'(4)) ? $signed({1'b0, RATIO_ONE - rx})
                                   : $signed({1'b0, rx});

  always_ff @(posedge clk) begin
    if (rst) begin
      bstep <= '0;
    end else if (cmd.scan_start) begin
      bstep <= '0;
    end else if (cmd.blend_run && bstep != BLEND_LAST) begin
      bstep <= bstep + BSW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.blend_run) begin
      case (bstep)
        BSW'(1): p <= PW'(hrd) * PW'(wy_m);
        BSW'(2): begin
          t <= TW'(p);
          p <= PW'(hrd) * PW'(wy_m);
        end
        BSW'(3): begin
          t <= t + TW'(p);
          p <= PW'(hrd) * PW'(wy_m);
        end
        BSW'(4): begin
          q <= AW'(t) * AW'(wx_m);
          t <= TW'(p);
          p <= PW'(hrd) * PW'(wy_m);
        end
        BSW'(5): begin
          acc <= q;
          t   <= t + TW'(p);
        end
        BSW'(6): q <= AW'(t) * AW'(wx_m);
        BSW'(7): acc <= acc + q;
        default: ;
      endcase
    end
  end

  // round to nearest, ties upward
  assign rnd = acc + (AW'(1) <<< (2 * Q_W - 1));

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      height  <= rnd[2*Q_W+VAL_W-1:2*Q_W];
      cell_x  <= IDX_W'(cx);
      cell_y  <= IDX_W'(cy);
      ratio_x <= rx;
      ratio_y <= ry;
    end
  end

  always_comb begin
    st            = '0;
    // operation of the request on offer, taken by the controller on acceptance
    st.op         = operation;
    st.scan_done  = (rk == n_sel) && !pv;
    st.need_div   = !low_f && !high_f && !snap_f && int_f;
    st.div_done   = (dcnt == DCW'(Q_W));
    st.blend_done = (bstep == BLEND_LAST);
  end

endmodule

// ===== design/grid_bilinear_interpolator.sv =====
// top level of the grid bilinear interpolator
`timescale 1ns / 1ps
//
// bilinear interpolation over a stored rectilinear height grid
// s_axis carries one request: tuser is the operation (write x node, write
//   y node, write height, query); tdata the indices, write value and query point
// m_axis carries one result per query: height, cells and ratios per axis
// cfg_we / cfg_index / cfg_data set node counts and snap tolerance; write
//   only while idle
// a write request gives no result
// a query scans the x nodes, then the y nodes, then blends the four corners;
//   the node scan reads one position per cycle from the one read port of each
//   position memory, and a ratio that needs a division goes through the
//   shared restoring divider
// one request at a time; s_axis_tready is high only when idle
// the result sits in an output register, so writes go on while it waits;
//   a new query finishes and then holds until m_axis frees
// reset clears control state and loads counts 2, 2 and tolerance 7;
//   grid memories hold nothing defined until written
//
`include "grid_bilinear_interpolator_defines.svh"

module grid_bilinear_interpolator #(
  parameter int MAX_X_NODES = gbi_pkg::DEF_MAX_X_NODES,
  parameter int MAX_Y_NODES = gbi_pkg::DEF_MAX_Y_NODES
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [gbi_pkg::CFGI_W-1:0]      cfg_index,
  input  logic [gbi_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // node_x_index, node_y_index, write_value, query_x, query_y, zero pad
  input  logic [111:0]                    s_axis_tdata,
  // operation
  input  logic [gbi_pkg::OP_W-1:0]        s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // height, cell_x, cell_y, ratio_x, ratio_y, zero pad
  output logic [79:0]                     m_axis_tdata
);
  import gbi_pkg::*;

  cmd_t    cmd;
  status_t st;

  logic signed [VAL_W-1:0] height;
  logic [IDX_W-1:0]        cell_x, cell_y;
  logic [RATIO_W-1:0]      ratio_x, ratio_y;

  // sequencing
  gbi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .st        (st)
  );

  // storage, scan, divider and blend
  gbi_datapath #(
    .MAX_X_NODES (MAX_X_NODES),
    .MAX_Y_NODES (MAX_Y_NODES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .operation    (op_t'(s_axis_tuser)),
    .node_x_index (s_axis_tdata[5:0]),
    .node_y_index (s_axis_tdata[11:6]),
    .write_value  (s_axis_tdata[43:12]),
    .query_x      (s_axis_tdata[75:44]),
    .query_y      (s_axis_tdata[107:76]),
    .cmd          (cmd),
    .st           (st),
    .height       (height),
    .cell_x       (cell_x),
    .cell_y       (cell_y),
    .ratio_x      (ratio_x),
    .ratio_y      (ratio_y)
  );

  // result packing, written highest field first, so height lands in the lowest bits
  assign m_axis_tdata = {2'b00, ratio_y, ratio_x, cell_y, cell_x, height};

  // an accepted request always keeps the block busy for the next cycle
  `GBI_ASSERT_NEXT(a_busy_after_request, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // a loaded result shows on the output next cycle
  `GBI_ASSERT_NEXT(a_result_shown, cmd.load_result, m_axis_tvalid)
  // scan, divider and blend never run together
  `GBI_ASSERT_NOW(a_one_unit, 1'b1, $onehot0({cmd.scan_run, cmd.div_run, cmd.blend_run}))
  // a result is only loaded into a free output slot
  `GBI_ASSERT_NOW(a_no_overwrite, cmd.load_result, !m_axis_tvalid || m_axis_tready)

endmodule

// ===== bench/grid_bilinear_interpolator_checker.sv =====
// request and result checker with a grid predictor for the bilinear interpolator
`timescale 1ns / 1ps

module grid_bilinear_interpolator_checker
  import gbi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [111:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [79:0] m_axis_tdata,
  output int          errors,
  output int          pending
);

  // highest field first, so height lands in the lowest bits
  typedef struct packed {
    logic [16:0] ratio_y;
    logic [16:0] ratio_x;
    logic [5:0]  cell_y;
    logic [5:0]  cell_x;
    logic [31:0] height;
  } answer_t;

  logic signed [31:0] x_pos [64];
  logic signed [31:0] y_pos [64];
  logic signed [31:0] heights [64][64];
  logic [6:0]  x_count, y_count;
  logic [15:0] tol;
  answer_t     due_answers[$];

  function automatic int clamp_nodes(input logic [6:0] c);
    if (c < 2) return 2;
    if (c > 64) return 64;
    return c;
  endfunction

  // cell and Q1.16 fraction along one axis
  function automatic void resolve_axis(input logic signed [31:0] v,
                                       input logic signed [31:0] pos [64],
                                       input int n, input longint snap,
                                       output int cell_idx, output longint ratio);
    longint d;
    longint num, den;
    cell_idx = 0;
    ratio = 0;
    if (longint'(v) < longint'(pos[0])) return;
    if (longint'(v) > longint'(pos[n-1])) begin
      cell_idx = n - 2;
      ratio = 65536;
      return;
    end
    for (int k = 0; k < n; k++) begin
      d = longint'(v) - longint'(pos[k]);
      if (d < 0) d = -d;
      if (d == 0 || d < snap) begin
        if (k != n - 1) begin
          cell_idx = k;
        end else begin
          cell_idx = n - 2;
          ratio = 65536;
        end
        return;
      end
    end
    for (int k = 0; k + 1 < n; k++) begin
      if (longint'(v) > longint'(pos[k]) && longint'(v) < longint'(pos[k+1])) begin
        num = longint'(v) - longint'(pos[k]);
        den = longint'(pos[k+1]) - longint'(pos[k]);
        cell_idx = k;
        ratio = (num <<< 16) / den;
        return;
      end
    end
  endfunction

  function automatic answer_t interpolate(input logic signed [31:0] qx,
                                          input logic signed [31:0] qy);
    answer_t a;
    int cx, cy;
    longint rx, ry;
    logic [63:0] acc, r;
    resolve_axis(qx, x_pos, clamp_nodes(x_count), longint'(tol), cx, rx);
    resolve_axis(qy, y_pos, clamp_nodes(y_count), longint'(tol), cy, ry);
    // wraps modulo 2^64, the true sum always fits
    acc = longint'(heights[cx][cy])     * ((65536 - rx) * (65536 - ry))
        + longint'(heights[cx+1][cy])   * (rx * (65536 - ry))
        + longint'(heights[cx][cy+1])   * ((65536 - rx) * ry)
        + longint'(heights[cx+1][cy+1]) * (rx * ry);
    r = (acc ^ 64'h8000_0000_0000_0000) + 64'h8000_0000;
    a.height  = r[63:32] ^ 32'h8000_0000;
    a.cell_x  = cx[5:0];
    a.cell_y  = cy[5:0];
    a.ratio_x = rx[16:0];
    a.ratio_y = ry[16:0];
    return a;
  endfunction

  task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
    errors++;
    if (errors <= 40)
      $display("%0t mismatch %s expected %h actual %h", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    answer_t got, want;
    logic [5:0] xi, yi;
    logic [31:0] wv;
    if (rst) begin
      x_count = RST_NODE_COUNT;
      y_count = RST_NODE_COUNT;
      tol = RST_SNAP_TOL;
      due_answers = {};
      errors = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_X_COUNT:  x_count = cfg_data[6:0];
          CFG_Y_COUNT:  y_count = cfg_data[6:0];
          CFG_SNAP_TOL: tol = cfg_data;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[77:0];
        if (due_answers.size() == 0) begin
          errors++;
          $display("%0t unexpected result %h", $time, m_axis_tdata);
        end else begin
          want = due_answers.pop_front();
          if (got.height !== want.height) report("height", want.height, got.height);
          if (got.cell_x !== want.cell_x) report("cell_x", want.cell_x, got.cell_x);
          if (got.cell_y !== want.cell_y) report("cell_y", want.cell_y, got.cell_y);
          if (got.ratio_x !== want.ratio_x) report("ratio_x", want.ratio_x, got.ratio_x);
          if (got.ratio_y !== want.ratio_y) report("ratio_y", want.ratio_y, got.ratio_y);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        xi = s_axis_tdata[5:0];
        yi = s_axis_tdata[11:6];
        wv = s_axis_tdata[43:12];
        case (op_t'(s_axis_tuser))
          OP_WRITE_X:      x_pos[xi] = wv;
          OP_WRITE_Y:      y_pos[yi] = wv;
          OP_WRITE_HEIGHT: heights[xi][yi] = wv;
          OP_QUERY:        due_answers.push_back(
                             interpolate(s_axis_tdata[75:44], s_axis_tdata[107:76]));
          default: ;
        endcase
      end
    end
    pending = due_answers.size();
  end

endmodule

// ===== bench/grid_bilinear_interpolator_test.sv =====
// stimulus and verdict for the grid bilinear interpolator
`timescale 1ns / 1ps

module grid_bilinear_interpolator_test;
  import gbi_pkg::*;

  logic         clk = 0;
  logic         rst = 1;
  logic         cfg_we = 0;
  logic [1:0]   cfg_index = '0;
  logic [15:0]  cfg_data = '0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata = '0;  // node_x_index, node_y_index, write_value, query_x, query_y
  logic [1:0]   s_axis_tuser = '0;  // operation
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [79:0]  m_axis_tdata;       // height, cell_x, cell_y, ratio_x, ratio_y
  int           errors, pending;

  // stimulus-side copy of the grid positions, used to aim queries
  logic signed [31:0] x_nodes [64];
  logic signed [31:0] y_nodes [64];
  int  nx, ny, snap, sent;
  bit  calm;       // no sender gaps while set
  bit  sink_calm;  // no result stalls while set
  int  quiet_cycles;

  grid_bilinear_interpolator u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  grid_bilinear_interpolator_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .errors(errors), .pending(pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // result side: random stalls except in calm stretches
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0 && !sink_calm) begin
        m_axis_tready = 0;
        stall--;
      end else begin
        m_axis_tready = 1;
        stall = 0;
        if (!sink_calm && $urandom_range(99) < 20) stall = pick_gap();
      end
    end
  end

  // hangs are caught by counting cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || cfg_we || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 5000) begin
      $display("grid_bilinear_interpolator_test NOT OK");
      $finish;
    end
  end

  task automatic send_request(input op_t op, input logic [5:0] xi, input logic [5:0] yi,
                              input logic [31:0] wv, input logic [31:0] qx,
                              input logic [31:0] qy);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid = 0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1;
    s_axis_tuser = op;
    s_axis_tdata = {4'b0, qy, qx, wv, yi, xi};
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    s_axis_tvalid = 0;
    sent++;
  endtask

  task automatic put_node(input op_t op, input int idx, input logic [31:0] v);
    if (op == OP_WRITE_X) x_nodes[idx] = v;
    if (op == OP_WRITE_Y) y_nodes[idx] = v;
    send_request(op, idx[5:0], idx[5:0], v, $urandom, $urandom);
  endtask

  task automatic ask(input logic [31:0] qx, input logic [31:0] qy);
    send_request(OP_QUERY, 6'($urandom), 6'($urandom), $urandom, qx, qy);
  endtask

  // registers change only once the block has drained
  task automatic set_registers(input logic [15:0] xc, input logic [15:0] yc,
                               input logic [15:0] t);
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we = 1;
    cfg_index = CFG_X_COUNT;  cfg_data = xc;  @(negedge clk);
    cfg_index = CFG_Y_COUNT;  cfg_data = yc;  @(negedge clk);
    cfg_index = CFG_SNAP_TOL; cfg_data = t;   @(negedge clk);
    cfg_we = 0;
    nx = (xc[6:0] < 2) ? 2 : (xc[6:0] > 64) ? 64 : xc[6:0];
    ny = (yc[6:0] < 2) ? 2 : (yc[6:0] > 64) ? 64 : yc[6:0];
    snap = t;
  endtask

  function automatic logic [31:0] fit32(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // coordinate aimed at a node, near a node, a cell, the edges or anywhere
  function automatic logic [31:0] aim(input logic signed [31:0] pos [64], input int n);
    int k;
    longint lo, hi;
    k = $urandom_range(n - 1);
    case ($urandom_range(6))
      0: return pos[k];
      1: return fit32(longint'(pos[k]) + $signed($urandom_range(snap + 2)) *
                      ($urandom_range(1) ? 1 : -1));
      2: return fit32(longint'(pos[0]) - $urandom_range(1 << 20, 1));
      3: return fit32(longint'(pos[n-1]) + $urandom_range(1 << 20, 1));
      4: return $urandom;
      default: begin
        k = $urandom_range(n - 2);
        lo = pos[k];
        hi = pos[k+1];
        if (hi <= lo) return pos[k];
        return fit32(lo + longint'({$urandom, $urandom} % (hi - lo + 1)));
      end
    endcase
  endfunction

  // full grid load for the node counts in use
  task automatic load_grid(input bit rising);
    longint p;
    bit tiny;
    tiny = $urandom_range(1);
    for (int a = 0; a < 2; a++) begin
      p = $signed($urandom_range(1 << 30)) - (1 << 29);
      for (int k = 0; k < (a == 0 ? nx : ny); k++) begin
        if (rising) p += tiny ? $urandom_range(40, 1) : $urandom_range(1 << 24, 1);
        else p = $signed($urandom);
        put_node(a == 0 ? OP_WRITE_X : OP_WRITE_Y, k, p[31:0]);
      end
    end
    for (int i = 0; i < nx; i++)
      for (int j = 0; j < ny; j++)
        send_request(OP_WRITE_HEIGHT, 6'(i), 6'(j),
                     $urandom_range(9) == 0 ? ($urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000)
                                            : $urandom,
                     $urandom, $urandom);
  endtask

  initial begin
    int phase, queries;
    logic [15:0] xc, yc, t;
    sent = 0;
    calm = 0;
    sink_calm = 0;
    nx = 2;
    ny = 2;
    snap = RST_SNAP_TOL;
    repeat (10) @(negedge clk);
    rst = 0;

    // directed: reset counts, one cell 0x10000 wide in x and 0x20000 in y, with extreme and small corner heights
    put_node(OP_WRITE_X, 0, 0);
    put_node(OP_WRITE_X, 1, 32'h0001_0000);
    put_node(OP_WRITE_Y, 0, 0);
    put_node(OP_WRITE_Y, 1, 32'h0002_0000);
    send_request(OP_WRITE_HEIGHT, 0, 0, 32'h7FFF_FFFF, 0, 0);
    send_request(OP_WRITE_HEIGHT, 1, 0, 32'h8000_0000, 0, 0);
    send_request(OP_WRITE_HEIGHT, 0, 1, 32'h0000_0001, 0, 0);
    send_request(OP_WRITE_HEIGHT, 1, 1, 32'hFFFF_FFFF, 0, 0);
    ask(32'h8000_0000, 32'h8000_0000);   // below both first nodes
    ask(32'h7FFF_FFFF, 32'h7FFF_FFFF);   // above both last nodes
    ask(32'h0000_0000, 32'h0002_0000);   // exactly on nodes
    ask(32'h0000_0003, 32'h0001_FFFA);   // within tolerance of nodes
    ask(32'h0000_8000, 32'h0001_0000);   // mid cell
    ask(32'h0000_0007, 32'h0000_0001);   // just outside and inside tolerance
    // zero tolerance: only an exact hit snaps
    set_registers(16'd2, 16'd2, 16'd0);
    ask(32'h0001_0000, 32'h0000_0000);
    ask(32'h0000_FFFF, 32'h0000_0001);
    // top indices; later grid loads overwrite these two node values but not this height
    put_node(OP_WRITE_X, 63, 32'h8000_0000);
    put_node(OP_WRITE_Y, 63, 32'h7FFF_FFFF);
    send_request(OP_WRITE_HEIGHT, 63, 63, 32'h5555_AAAA, 0, 0);

    // random phases, each with its own register setting and grid
    phase = 0;
    while (sent < 1200 || phase < 6) begin
      case (phase)
        1: begin xc = 16'd0;   yc = 16'd1;   t = 16'hFFFF; end
        2: begin xc = 16'd127; yc = 16'd2;   t = 16'd0;    end
        3: begin xc = 16'd64;  yc = 16'd3;   t = 16'd7;    end
        4: begin xc = 16'd2;   yc = 16'd200; t = 16'd1;    end
        default: begin
          xc = $urandom_range(8, 2);
          yc = $urandom_range(8, 2);
          t = $urandom_range(3) == 0 ? $urandom : $urandom_range(20);
        end
      endcase
      calm = ($urandom_range(4) == 0);
      sink_calm = ($urandom_range(4) == 0);
      set_registers(xc, yc, t);
      load_grid($urandom_range(7) != 0);
      queries = $urandom_range(40, 20);
      for (int q = 0; q < queries; q++) begin
        if ($urandom_range(9) == 0)
          send_request(OP_WRITE_HEIGHT, 6'($urandom_range(nx - 1)), 6'($urandom_range(ny - 1)),
                       $urandom, $urandom, $urandom);
        ask(aim(x_nodes, nx), aim(y_nodes, ny));
      end
      phase++;
    end

    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (errors == 0)
      $display("grid_bilinear_interpolator_test OK");
    else
      $display("grid_bilinear_interpolator_test NOT OK");
    $finish;
  end

endmodule
